// File: src/ssm_pkg.sv
// shared types and constants for the stub sector membership block
`default_nettype none
package ssm_pkg;

	// stream word widths
	localparam int IN_W        = 131;
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_W       = 10;
	localparam int OUT_TDATA_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_OUTER_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_OUTER_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAM_HALF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_RADIUS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PHI_CENTER   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PHI_HALF     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TRK_NOM_TOL  = 3'd7;

	// mode flag bit positions
	localparam int MF_STRIP_ETA = 0;
	localparam int MF_STRIP_PHI = 1;
	localparam int MF_STUB_PHI  = 2;
	localparam int MF_TRACK_PHI = 3;
	localparam int MF_CALC_RES  = 4;

	// register reset values
	localparam logic [4:0]  RST_MODE_FLAGS = 5'd12;
	localparam logic [14:0] RST_BEAM_HALF  = 15'd960;
	localparam logic [13:0] RST_REF_RADIUS = 14'd3200;
	localparam logic [14:0] RST_PHI_HALF   = 15'd2048;

	// edge arithmetic widths, sized for up to eight subsectors
	localparam int EDGE_W = 22;
	localparam int SBW_W  = 19;
	localparam int P_W    = 48;

	typedef struct packed {
		logic [14:0] track_phi_strip_err;
		logic [14:0] track_phi_res;
		logic [15:0] track_phi;
		logic [14:0] curvature_tol;
		logic [15:0] hit_phi;
		logic [11:0] z_error;
		logic [11:0] radius_error;
		logic [15:0] hit_z;
		logic [13:0] hit_radius;
	} item_t;

	// eta edges of one slice at reference radius, scaled by the slice count
	typedef struct packed {
		logic [EDGE_W-1:0] lo;
		logic [EDGE_W-1:0] hi;
		logic [EDGE_W-1:0] a;
		logic [EDGE_W-1:0] b;
		logic [SBW_W-1:0]  sbw;
	} edge_t;

	typedef struct packed {
		logic [4:0]  mode;
		logic [15:0] center;
		logic [14:0] half_width;
		logic [14:0] nom_tol;
	} phi_cfg_t;

	typedef struct packed {
		logic [7:0] mask;
		logic       in_eta;
		logic       in_phi;
	} result_t;

endpackage
`default_nettype wire

// File: src/ssm_phi.sv
// stub and track phi window tests with wrapped angle difference
`default_nettype none
module ssm_phi (
	input  ssm_pkg::phi_cfg_t cfg,
	input  ssm_pkg::item_t    item,
	output logic              in_phi
);
	import ssm_pkg::*;

	logic [15:0] d_stub;
	logic [15:0] d_trk;
	logic [16:0] ad_stub;
	logic [16:0] ad_trk;
	logic [16:0] stub_lim;
	logic [14:0] tol;
	logic [17:0] trk_lim;
	logic        stub_ok;
	logic        trk_ok;

	always_comb begin
		d_stub = item.hit_phi - cfg.center;
		d_trk  = item.track_phi - cfg.center;
		// magnitude of a 16-bit wrapped difference, -32768 gives 32768
		ad_stub = d_stub[15] ? (~{1'b1, d_stub} + 17'd1) : {1'b0, d_stub};
		ad_trk  = d_trk[15] ? (~{1'b1, d_trk} + 17'd1) : {1'b0, d_trk};

		stub_lim = {2'b00, cfg.half_width} + {2'b00, item.curvature_tol};
		stub_ok  = !cfg.mode[MF_STUB_PHI] || (ad_stub <= stub_lim);

		tol = (cfg.mode[MF_CALC_RES] && (item.track_phi_res < cfg.nom_tol)) ?
			item.track_phi_res : cfg.nom_tol;
		trk_lim = {3'b000, cfg.half_width} + {3'b000, tol} +
			(cfg.mode[MF_STRIP_PHI] ? {3'b000, item.track_phi_strip_err} : 18'd0);
		trk_ok = !cfg.mode[MF_TRACK_PHI] || ({1'b0, ad_trk} <= trk_lim);

		in_phi = stub_ok && trk_ok;
	end

endmodule
`default_nettype wire

// File: src/ssm_eta.sv
// eta window test of one hit against one slice, plain or strip-widened
`default_nettype none
module ssm_eta #(
	parameter int SCALE = 1
) (
	input  logic           strip,
	input  logic [13:0]    rr,
	input  logic [14:0]    bw,
	input  ssm_pkg::edge_t edges,
	input  ssm_pkg::item_t item,
	output logic           hit_in
);
	import ssm_pkg::*;

	localparam logic signed [P_W-1:0] SCALE_P = P_W'(SCALE);

	logic signed [14:0]          r_s;
	logic signed [14:0]          rr_s;
	logic signed [14:0]          diff;
	logic signed [14:0]          dr_s;
	logic signed [15:0]          z_s;
	logic signed [30:0]          zrr;
	logic signed [P_W-1:0]       lhs;
	logic signed [EDGE_W+14:0]   lo_r;
	logic signed [EDGE_W+14:0]   hi_r;
	logic signed [SBW_W+14:0]    bw_dr;
	logic signed [P_W-1:0]       lim_lo;
	logic signed [P_W-1:0]       lim_hi;
	logic                        plain_ok;
	logic signed [17:0]          zl;
	logic signed [17:0]          zh;
	logic signed [32:0]          zl_rr;
	logic signed [32:0]          zh_rr;
	logic signed [P_W-1:0]       lhs_l;
	logic signed [P_W-1:0]       lhs_h;
	logic signed [15:0]          r16;
	logic signed [15:0]          re16;
	logic signed [15:0]          ra;
	logic signed [15:0]          rb;
	logic signed [EDGE_W+15:0]   ra_a;
	logic signed [EDGE_W+15:0]   rb_b;
	logic                        strip_ok;

	always_comb begin
		r_s  = $signed({1'b0, item.hit_radius});
		rr_s = $signed({1'b0, rr});
		z_s  = $signed(item.hit_z);

		// plain line test
		diff   = r_s - rr_s;
		dr_s   = diff[14] ? -diff : diff;
		zrr    = 31'(z_s) * 31'(rr_s);
		lhs    = P_W'(zrr) * SCALE_P;
		lo_r   = (EDGE_W+15)'($signed(edges.lo)) * (EDGE_W+15)'(r_s);
		hi_r   = (EDGE_W+15)'($signed(edges.hi)) * (EDGE_W+15)'(r_s);
		bw_dr  = (SBW_W+15)'($signed(edges.sbw)) * (SBW_W+15)'(dr_s);
		lim_lo = P_W'(lo_r) - P_W'(bw_dr);
		lim_hi = P_W'(hi_r) + P_W'(bw_dr);
		plain_ok = (lhs > lim_lo) && (lhs < lim_hi);

		// strip test, edges widened by radius and z errors
		zl    = 18'(z_s) + $signed({6'b0, item.z_error}) + $signed({3'b0, bw});
		zh    = 18'(z_s) - $signed({6'b0, item.z_error}) - $signed({3'b0, bw});
		zl_rr = 33'(zl) * 33'(rr_s);
		zh_rr = 33'(zh) * 33'(rr_s);
		lhs_l = P_W'(zl_rr) * SCALE_P;
		lhs_h = P_W'(zh_rr) * SCALE_P;
		r16   = 16'(r_s);
		re16  = $signed({4'b0, item.radius_error});
		ra    = edges.a[EDGE_W-1] ? (r16 + re16) : (r16 - re16);
		rb    = edges.b[EDGE_W-1] ? (r16 - re16) : (r16 + re16);
		ra_a  = (EDGE_W+16)'(ra) * (EDGE_W+16)'($signed(edges.a));
		rb_b  = (EDGE_W+16)'(rb) * (EDGE_W+16)'($signed(edges.b));
		strip_ok = (lhs_l > P_W'(ra_a)) && (lhs_h < P_W'(rb_b));

		hit_in = strip ? strip_ok : plain_ok;
	end

endmodule
`default_nettype wire

// File: src/stub_sector_membership.sv
// top level: eta-phi sector membership of one detector hit per word
// flow: an accepted word is held in the input register, and its result word is
// then registered in the result register and shown on m_axis
// throughput: one word per cycle; the input register and the result register
// form a two-deep pipeline stalled only by m_axis_tready
// reset: arst_n clears the valid bits and loads the register reset values
`default_nettype none
module stub_sector_membership #(
	parameter int SUBSECTORS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes, always taken
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// hit words
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// hit_radius, hit_z, radius_error, z_error, hit_phi, curvature_tol,
	// track_phi, track_phi_res, track_phi_strip_err, zero fill
	input  logic [ssm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// result words
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// in_phi, in_eta, subsector_mask, zero fill
	output logic [ssm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import ssm_pkg::*;

	localparam int N = SUBSECTORS;

	// configuration registers
	logic [4:0]  mode_q;
	logic [15:0] z_lo_q;
	logic [15:0] z_hi_q;
	logic [14:0] bw_q;
	logic [13:0] rr_q;
	logic [15:0] phi_center_q;
	logic [14:0] phi_half_q;
	logic [14:0] nom_tol_q;

	// pipeline
	logic    v_s1;
	logic    v_s2;
	item_t   item_s1;
	item_t   item_in;
	result_t res_s2;
	result_t res_next;
	logic    adv;

	// edges derived from configuration; entry N is the whole eta range
	edge_t edge_d [0:N];
	edge_t edge_q [0:N];

	logic [EDGE_W-1:0] lo_x;
	logic [EDGE_W-1:0] hi_x;
	logic [EDGE_W-1:0] dlt;
	logic [SBW_W-1:0]  sbw_n;
	logic [SBW_W-1:0]  sbw_1;

	logic [N-1:0] slice_in;
	logic         in_eta_c;
	logic         in_phi_c;
	phi_cfg_t     phi_cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE_FLAGS;
			z_lo_q       <= '0;
			z_hi_q       <= '0;
			bw_q         <= RST_BEAM_HALF;
			rr_q         <= RST_REF_RADIUS;
			phi_center_q <= '0;
			phi_half_q   <= RST_PHI_HALF;
			nom_tol_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE_FLAGS:   mode_q       <= cfg_data[4:0];
				CFG_Z_OUTER_LOW:  z_lo_q       <= cfg_data;
				CFG_Z_OUTER_HIGH: z_hi_q       <= cfg_data;
				CFG_BEAM_HALF:    bw_q         <= cfg_data[14:0];
				CFG_REF_RADIUS:   rr_q         <= cfg_data[13:0];
				CFG_PHI_CENTER:   phi_center_q <= cfg_data;
				CFG_PHI_HALF:     phi_half_q   <= cfg_data[14:0];
				CFG_TRK_NOM_TOL:  nom_tol_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// slice i spans N*lo + i*(hi-lo) .. N*lo + (i+1)*(hi-lo), all scaled by N;
	// a and b are the edges moved inward by the scaled beam half length
	assign lo_x  = EDGE_W'($signed(z_lo_q));
	assign hi_x  = EDGE_W'($signed(z_hi_q));
	assign dlt   = hi_x - lo_x;
	assign sbw_n = SBW_W'(bw_q) * SBW_W'(N);
	assign sbw_1 = SBW_W'(bw_q);

	for (genvar k = 0; k <= N; k++) begin : g_edge
		if (k < N) begin : g_slice
			localparam logic [EDGE_W-1:0] N_E  = EDGE_W'(N);
			localparam logic [EDGE_W-1:0] I_E  = EDGE_W'(k);
			localparam logic [EDGE_W-1:0] I1_E = EDGE_W'(k + 1);
			always_comb begin
				edge_d[k].lo  = N_E * lo_x + I_E * dlt;
				edge_d[k].hi  = N_E * lo_x + I1_E * dlt;
				edge_d[k].a   = edge_d[k].lo + EDGE_W'(sbw_n);
				edge_d[k].b   = edge_d[k].hi - EDGE_W'(sbw_n);
				edge_d[k].sbw = sbw_n;
			end
		end else begin : g_full
			always_comb begin
				edge_d[k].lo  = lo_x;
				edge_d[k].hi  = hi_x;
				edge_d[k].a   = lo_x + EDGE_W'(sbw_1);
				edge_d[k].b   = hi_x - EDGE_W'(sbw_1);
				edge_d[k].sbw = sbw_1;
			end
		end
		// registered from the configuration registers; an item already in the input register may still meet the old edges
		always_ff @(posedge clk) begin
			edge_q[k] <= edge_d[k];
		end
	end

	// unpack the input word, first field lowest
	always_comb begin
		item_in.hit_radius          = s_axis_tdata[13:0];
		item_in.hit_z               = s_axis_tdata[29:14];
		item_in.radius_error        = s_axis_tdata[41:30];
		item_in.z_error             = s_axis_tdata[53:42];
		item_in.hit_phi             = s_axis_tdata[69:54];
		item_in.curvature_tol       = s_axis_tdata[84:70];
		item_in.track_phi           = s_axis_tdata[100:85];
		item_in.track_phi_res       = s_axis_tdata[115:101];
		item_in.track_phi_strip_err = s_axis_tdata[130:116];
	end

	// stall only when the result register is full and not taken
	assign adv           = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
		if (adv && v_s1) begin
			res_s2 <= res_next;
		end
	end

	// compare logic between the two registers
	assign phi_cfg.mode       = mode_q;
	assign phi_cfg.center     = phi_center_q;
	assign phi_cfg.half_width = phi_half_q;
	assign phi_cfg.nom_tol    = nom_tol_q;

	ssm_phi u_phi (
		.cfg    (phi_cfg),
		.item   (item_s1),
		.in_phi (in_phi_c)
	);

	for (genvar k = 0; k <= N; k++) begin : g_eta
		if (k < N) begin : g_slice
			ssm_eta #(.SCALE(N)) u_eta (
				.strip  (mode_q[MF_STRIP_ETA]),
				.rr     (rr_q),
				.bw     (bw_q),
				.edges  (edge_q[k]),
				.item   (item_s1),
				.hit_in (slice_in[k])
			);
		end else begin : g_full
			ssm_eta #(.SCALE(1)) u_eta (
				.strip  (mode_q[MF_STRIP_ETA]),
				.rr     (rr_q),
				.bw     (bw_q),
				.edges  (edge_q[k]),
				.item   (item_s1),
				.hit_in (in_eta_c)
			);
		end
	end

	// mask bits at and above the slice count stay zero
	assign res_next.mask   = 8'(slice_in);
	assign res_next.in_eta = in_eta_c;
	assign res_next.in_phi = in_phi_c;

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, res_s2};

	// unused subsector bits never show up in a result word
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((res_s2.mask >> N) == 8'd0))
		else $error("subsector bit set beyond slice count");

	// an empty result register never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// a stalled word in the input register stays there
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1)
		else $error("word lost from input register");

	// a result appears only after a word sat in the input register
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_s1))
		else $error("result without a source word");

endmodule
`default_nettype wire
